@@ design/ptts_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ptts_pkg
// Shared types and constants of the periodic task tick scheduler.
// ----------------------------------------------------------------------------
package ptts_pkg;

  localparam int NUM_SLOTS = 8;
  localparam int IDX_W     = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
  localparam int CNT_W     = 32;
  localparam int ENTRY_W   = 2 * CNT_W;
  localparam int SLOT_W    = 3;
  localparam int CMD_W     = 3;
  localparam int KIND_W    = 2;
  localparam int S_DATA_W  = 72;
  localparam int M_DATA_W  = 8;

  typedef enum logic [CMD_W-1:0] {
    CMD_TICK    = 3'd0,
    CMD_CREATE  = 3'd1,
    CMD_RESUME  = 3'd2,
    CMD_SUSPEND = 3'd3,
    CMD_DELETE  = 3'd4
  } cmd_e;

  typedef enum logic [KIND_W-1:0] {
    KIND_STATUS = 2'd0,
    KIND_FIRED  = 2'd1,
    KIND_DONE   = 2'd2
  } kind_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CMD,
    ST_EVAL,
    ST_DONE
  } state_e;

  typedef struct packed {
    kind_e             kind;
    logic [SLOT_W-1:0] fired_slot;
    logic              status;
    logic              last;
  } res_t;

  // slot entry: period in the upper half, countdown in the lower half
  typedef struct packed {
    logic               rd_en;
    logic [IDX_W-1:0]   rd_addr;
    logic               wr_en;
    logic [IDX_W-1:0]   wr_addr;
    logic [ENTRY_W-1:0] wdata;
  } ram_req_t;

endpackage

@@ design/periodic_task_tick_scheduler.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// periodic_task_tick_scheduler
// Priority-indexed task slot table with tick-driven countdowns.
// ----------------------------------------------------------------------------
// command: after accept, ST_CMD hands the status item to the output register and
//   returns to ST_IDLE, where the next item is accepted
// tick: ST_EVAL walks every slot, holding while the output register cannot take a
//   fired item, then ST_DONE hands the done item on before the next item is accepted
// reset clears the used and suspended flags at once; the slot memory is not
//   cleared, a tick acts only on entries of used slots, which create has written
module periodic_task_tick_scheduler
  import ptts_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  input  logic [CMD_W-1:0]    s_axis_tuser,  // cmd
  input  logic [S_DATA_W-1:0] s_axis_tdata,  // slot[2:0], period[34:3], first_delay[66:35]
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  output logic [KIND_W-1:0]   m_axis_tuser,  // kind
  output logic [M_DATA_W-1:0] m_axis_tdata,  // fired_slot[2:0], status[3]
  output logic                m_axis_tlast   // last
);

  ram_req_t           ram_req;
  logic [ENTRY_W-1:0] ram_rdata;
  logic               res_valid;
  logic               res_ready;
  res_t               res;
  res_t               out_res;

  ptts_slot_ram u_ram (
    .clk_i   (clk_i),
    .req_i   (ram_req),
    .rdata_o (ram_rdata)
  );

  ptts_seq u_seq (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (s_axis_tvalid),
    .in_ready_o    (s_axis_tready),
    .cmd_i         (s_axis_tuser),
    .slot_i        (s_axis_tdata[SLOT_W-1:0]),
    .period_i      (s_axis_tdata[SLOT_W+CNT_W-1:SLOT_W]),
    .first_delay_i (s_axis_tdata[SLOT_W+2*CNT_W-1:SLOT_W+CNT_W]),
    .ram_req_o     (ram_req),
    .ram_rdata_i   (ram_rdata),
    .res_valid_o   (res_valid),
    .res_o         (res),
    .res_ready_i   (res_ready)
  );

  ptts_out_buf u_out (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (res_valid),
    .in_ready_o  (res_ready),
    .in_res_i    (res),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_res_o   (out_res)
  );

  assign m_axis_tuser = out_res.kind;
  assign m_axis_tdata = {{(M_DATA_W - SLOT_W - 1){1'b0}}, out_res.status, out_res.fired_slot};
  assign m_axis_tlast = out_res.last;

endmodule

@@ design/ptts_slot_ram.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ptts_slot_ram
// Simple dual-port slot memory holding period and countdown, registered read.
// ----------------------------------------------------------------------------
module ptts_slot_ram
  import ptts_pkg::*;
(
  input  logic               clk_i,
  input  ram_req_t           req_i,
  output logic [ENTRY_W-1:0] rdata_o
);

  logic [ENTRY_W-1:0] mem_q [NUM_SLOTS];
  logic [ENTRY_W-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (req_i.wr_en) begin
      mem_q[req_i.wr_addr] <= req_i.wdata;
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.rd_en) begin
      rdata_q <= mem_q[req_i.rd_addr];
    end
  end

  assign rdata_o = rdata_q;

endmodule

@@ design/ptts_seq.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ptts_seq
// Command decoder and tick walker: slot flags plus read-modify-write of the
// slot memory, one slot per cycle while no fired item is held back.
// ----------------------------------------------------------------------------
module ptts_seq
  import ptts_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [CMD_W-1:0]   cmd_i,
  input  logic [SLOT_W-1:0]  slot_i,
  input  logic [CNT_W-1:0]   period_i,
  input  logic [CNT_W-1:0]   first_delay_i,
  output ram_req_t           ram_req_o,
  input  logic [ENTRY_W-1:0] ram_rdata_i,
  output logic               res_valid_o,
  output res_t               res_o,
  input  logic               res_ready_i
);

  state_e state_q, state_d;
  logic [IDX_W-1:0]     idx_q, idx_d;
  logic [NUM_SLOTS-1:0] used_q, used_d;
  logic [NUM_SLOTS-1:0] susp_q, susp_d;
  logic [CMD_W-1:0]     cmd_q;
  logic [SLOT_W-1:0]    slot_q;
  logic [CNT_W-1:0]     period_q;
  logic [CNT_W-1:0]     delay_q;

  logic                 accept;
  logic                 in_range;
  logic [IDX_W-1:0]     slot_idx;
  logic [CNT_W-1:0]     cd;
  logic [CNT_W-1:0]     per;
  logic                 elig;
  logic                 fire;

  assign accept   = in_valid_i && in_ready_o;
  assign in_range = 32'(slot_q) < NUM_SLOTS;
  assign slot_idx = IDX_W'(slot_q);
  assign cd       = ram_rdata_i[CNT_W-1:0];
  assign per      = ram_rdata_i[ENTRY_W-1:CNT_W];
  assign elig     = used_q[idx_q] && !susp_q[idx_q];
  assign fire     = elig && (cd == '0);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      idx_q   <= '0;
      used_q  <= '0;
      susp_q  <= '0;
    end else begin
      state_q <= state_d;
      idx_q   <= idx_d;
      used_q  <= used_d;
      susp_q  <= susp_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      cmd_q    <= cmd_i;
      slot_q   <= slot_i;
      period_q <= period_i;
      delay_q  <= first_delay_i;
    end
  end

  always_comb begin
    state_d     = state_q;
    idx_d       = idx_q;
    used_d      = used_q;
    susp_d      = susp_q;
    in_ready_o  = 1'b0;
    ram_req_o   = '0;
    res_valid_o = 1'b0;
    res_o       = '{kind: KIND_STATUS, fired_slot: '0, status: 1'b0, last: 1'b1};

    case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          if (cmd_i == CMD_TICK) begin
            // fetch slot 0 so its entry is ready in the first walk cycle
            ram_req_o.rd_en   = 1'b1;
            ram_req_o.rd_addr = '0;
            idx_d             = '0;
            state_d           = ST_EVAL;
          end else begin
            state_d = ST_CMD;
          end
        end
      end

      ST_CMD: begin
        res_valid_o  = 1'b1;
        res_o.status = (cmd_q == CMD_CREATE) && (!in_range || used_q[slot_idx]);
        if (res_ready_i) begin
          state_d = ST_IDLE;
          case (cmd_q)
            CMD_CREATE: begin
              if (in_range && !used_q[slot_idx]) begin
                used_d[slot_idx]  = 1'b1;
                susp_d[slot_idx]  = 1'b0;
                ram_req_o.wr_en   = 1'b1;
                ram_req_o.wr_addr = slot_idx;
                ram_req_o.wdata   = {period_q, delay_q};
              end
            end
            CMD_RESUME: begin
              if (in_range) begin
                susp_d[slot_idx] = 1'b0;
              end
            end
            CMD_SUSPEND: begin
              if (in_range) begin
                susp_d[slot_idx] = 1'b1;
              end
            end
            CMD_DELETE: begin
              if (in_range) begin
                used_d[slot_idx] = 1'b0;
              end
            end
            default: ;
          endcase
        end
      end

      ST_EVAL: begin
        res_o.kind       = KIND_FIRED;
        res_o.fired_slot = SLOT_W'(idx_q);
        res_o.last       = 1'b0;
        res_valid_o      = fire;
        // hold the slot while a fired item cannot be handed on
        if (!fire || res_ready_i) begin
          ram_req_o.wr_en   = elig;
          ram_req_o.wr_addr = idx_q;
          ram_req_o.wdata   = {per, fire ? (per - 1'b1) : (cd - 1'b1)};
          if (idx_q == IDX_W'(NUM_SLOTS - 1)) begin
            state_d = ST_DONE;
          end else begin
            // next slot read overlaps this slot's write back
            ram_req_o.rd_en   = 1'b1;
            ram_req_o.rd_addr = idx_q + 1'b1;
            idx_d             = idx_q + 1'b1;
          end
        end
      end

      ST_DONE: begin
        res_o.kind  = KIND_DONE;
        res_valid_o = 1'b1;
        if (res_ready_i) begin
          state_d = ST_IDLE;
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // write and next read never hit the same slot in one cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ram_req_o.wr_en && ram_req_o.rd_en) |-> (ram_req_o.wr_addr != ram_req_o.rd_addr))
    else $error("ptts_seq: read and write hit the same slot");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_EVAL && res_valid_o && !res_ready_i) |=>
      ($stable(idx_q) && state_q == ST_EVAL))
    else $error("ptts_seq: walk advanced past an undelivered firing");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_EVAL) |=> ($stable(used_q) && $stable(susp_q)))
    else $error("ptts_seq: slot flags changed during a tick");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid_o && res_o.last) |-> (res_o.kind != KIND_FIRED))
    else $error("ptts_seq: firing item marked last");

endmodule

@@ design/ptts_out_buf.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ptts_out_buf
// One-entry output register between the sequencer and the result stream.
// ----------------------------------------------------------------------------
module ptts_out_buf
  import ptts_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_ready_o,
  input  res_t in_res_i,
  output logic out_valid_o,
  input  logic out_ready_i,
  output res_t out_res_o
);

  logic valid_q, valid_d;
  res_t res_q;

  assign in_ready_o = !valid_q || out_ready_i;
  assign valid_d    = (in_valid_i && in_ready_o) || (valid_q && !out_ready_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      res_q <= in_res_i;
    end
  end

  assign out_valid_o = valid_q;
  assign out_res_o   = res_q;

endmodule
